@@ hw/rtl/cartridge_work_ram_with_save_tracking_assert.svh @@
// Assertion macros for the cartridge work RAM block.
// Each macro takes a label, the clock, the reset, the condition terms and a message.
`ifndef CARTRIDGE_WORK_RAM_WITH_SAVE_TRACKING_ASSERT_SVH
`define CARTRIDGE_WORK_RAM_WITH_SAVE_TRACKING_ASSERT_SVH

`ifndef SYNTHESIS
`define CWRST_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define CWRST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CWRST_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define CWRST_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

@@ hw/rtl/cwrst_pkg.sv @@
package cwrst_pkg;

  // Default store depth in bytes.
  localparam int unsigned RAM_DEPTH_DEFAULT = 32768;

  localparam int unsigned ADDR_W = 16;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned GEN_W  = 64;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned BIT_CNT_W = $clog2(ADDR_W);

  // CPU window of the work RAM.
  localparam logic [ADDR_W-1:0] WINDOW_BASE = 16'h6000;
  localparam logic [ADDR_W-1:0] WINDOW_LAST = 16'h7fff;
  localparam int unsigned HIGH_SHIFT = 8;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ACK   = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_VOLATILE_BYTES = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BATTERY_BYTES  = 1'd1;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] cpu_address;
    logic [DATA_W-1:0] write_value;
    logic [GEN_W-1:0]  saved_generation;
  } cwrst_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              passed_on;
    logic              dirty;
    logic [GEN_W-1:0]  current_generation;
  } cwrst_rsp_t;

endpackage

@@ hw/rtl/cwrst_ram.sv @@
module cwrst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/cartridge_work_ram_with_save_tracking.sv @@
// Cartridge work RAM mapped at CPU address 0x6000 and up, with save tracking.
// A command is taken when start is high and busy is low; its single result
// appears on result for exactly one cycle with done high and cannot be held
// off, so the receiver must take it in that cycle. Steps per transaction:
// a command that needs no RAM access (open bus read, write with no RAM, write
// below the window, acknowledge) goes straight to the result step. A RAM
// read or write passes the read, check and result steps when the window
// offset is already below the active RAM size; when it has to be reduced
// modulo that size, a divide step comes first, where the remainder is found
// one address bit per cycle by a restoring divider. In every case done rises
// at the same edge at which busy falls, so the result is on the ports in the
// first cycle with busy low. The RAM access itself is a read, a wait for the
// registered read data, and a conditional write back. After reset the block
// sweeps the whole store to zero, one byte per cycle, with busy high;
// configuration writes are taken at any time, cfg_ready is always high.
`include "cartridge_work_ram_with_save_tracking_assert.svh"

module cartridge_work_ram_with_save_tracking
  import cwrst_pkg::*;
#(
  parameter int unsigned RAM_DEPTH = RAM_DEPTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  // Command channel.
  input  logic                   start,
  output logic                   busy,
  input  cwrst_req_t             request,
  // Result channel.
  output logic                   done,
  output cwrst_rsp_t             result,
  // Configuration write channel.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  // Index width of the store, width of a size value that can hold the
  // depth itself, and a common width for mixed-width compares.
  localparam int unsigned IDX_W  = $clog2(RAM_DEPTH);
  localparam int unsigned SIZE_W = $clog2(RAM_DEPTH + 1);
  localparam int unsigned SUM_W  = CFG_W + 1;
  localparam int unsigned CMP_W  = CFG_W + 2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIVIDE,
    ST_READ,
    ST_CHECK,
    ST_FINISH
  } state_t;

  state_t               state;
  logic [IDX_W-1:0]     clear_addr;
  logic [CFG_W-1:0]     volatile_bytes;
  logic [CFG_W-1:0]     battery_bytes;
  logic [GEN_W-1:0]     change_gen;
  logic [GEN_W-1:0]     persisted_gen;
  cwrst_req_t           req_q;
  logic [ADDR_W-1:0]    off_q;
  logic [SIZE_W-1:0]    size_q;
  logic [SIZE_W-1:0]    rem;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic [DATA_W-1:0]    rdata_q;
  logic                 passed_q;

  // Depth-capped size. Users keep configuration stable while busy; unchecked.
  logic [SUM_W-1:0]     size_sum;
  logic [SIZE_W-1:0]    size_next;
  logic [ADDR_W-1:0]    off_next;
  logic                 in_window;
  logic                 at_or_above_base;
  logic                 need_ram;

  // One step of the restoring remainder.
  logic [SIZE_W:0]      rem_shift;
  logic [SIZE_W-1:0]    rem_next;

  // Store ports.
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [DATA_W-1:0]    ram_wdata;
  logic [IDX_W-1:0]     ram_idx;
  logic [DATA_W-1:0]    ram_rdata;
  logic                 byte_changed;
  logic                 in_battery;

  always_comb begin
    size_sum = SUM_W'(volatile_bytes) + SUM_W'(battery_bytes);
    if (size_sum > SUM_W'(RAM_DEPTH)) begin
      size_next = SIZE_W'(RAM_DEPTH);
    end else begin
      size_next = SIZE_W'(size_sum);
    end
  end

  assign off_next         = request.cpu_address - WINDOW_BASE;
  assign at_or_above_base = request.cpu_address >= WINDOW_BASE;
  assign in_window        = at_or_above_base && (request.cpu_address <= WINDOW_LAST);

  // A RAM access is needed for a read inside the window or a write at or
  // above its base, and only when some RAM is configured.
  always_comb begin
    need_ram = 1'b0;
    if (size_next != '0) begin
      if (request.cmd == CMD_READ) begin
        need_ram = in_window;
      end else if (request.cmd == CMD_WRITE) begin
        need_ram = at_or_above_base;
      end
    end
  end

  assign rem_shift = {rem, off_q[ADDR_W-1]};
  assign rem_next  = (rem_shift >= (SIZE_W + 1)'(size_q)) ?
                     SIZE_W'(rem_shift - (SIZE_W + 1)'(size_q)) : SIZE_W'(rem_shift);

  assign ram_idx      = rem[IDX_W-1:0];
  assign byte_changed = ram_rdata != req_q.write_value;
  assign in_battery   = CMP_W'(rem) < CMP_W'(battery_bytes);

  // The store has one write port, shared by the reset sweep and write back.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ram_idx;
    ram_wdata = req_q.write_value;
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clear_addr;
      ram_wdata = '0;
    end else if (state == ST_CHECK) begin
      ram_we = (req_q.cmd == CMD_WRITE) && byte_changed;
    end
  end

  cwrst_ram #(
    .WIDTH(DATA_W),
    .DEPTH(RAM_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_idx),
    .rdata(ram_rdata)
  );

  assign busy      = state != ST_IDLE;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      volatile_bytes <= '0;
      battery_bytes  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_VOLATILE_BYTES: volatile_bytes <= cfg_data;
        REG_BATTERY_BYTES:  battery_bytes  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer: reset sweep, command decode, offset reduction, read, write
  // back and result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clear_addr    <= '0;
      change_gen    <= '0;
      persisted_gen <= '0;
      done          <= 1'b0;
    end else begin
      // The strobe is high only in the cycle after the result step.
      done <= state == ST_FINISH;
      unique case (state)
        ST_CLEAR: begin
          clear_addr <= clear_addr + IDX_W'(1);
          if (clear_addr == IDX_W'(RAM_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            req_q    <= request;
            off_q    <= off_next;
            size_q   <= size_next;
            bit_cnt  <= BIT_CNT_W'(ADDR_W - 1);
            // A read that misses the RAM returns the high address byte as
            // open bus; a RAM read fills this in after the store access.
            rdata_q  <= ((request.cmd == CMD_READ) && !need_ram) ?
                        DATA_W'(request.cpu_address >> HIGH_SHIFT) : '0;
            passed_q <= (request.cmd == CMD_WRITE) && (size_next == '0);
            if (need_ram) begin
              // An offset already below the size is its own remainder.
              if (CMP_W'(off_next) < CMP_W'(size_next)) begin
                rem   <= SIZE_W'(off_next);
                state <= ST_READ;
              end else begin
                rem   <= '0;
                state <= ST_DIVIDE;
              end
            end else begin
              if (request.cmd == CMD_ACK) begin
                if ((request.saved_generation > persisted_gen) &&
                    (request.saved_generation <= change_gen)) begin
                  persisted_gen <= request.saved_generation;
                end
              end
              state <= ST_FINISH;
            end
          end
        end
        ST_DIVIDE: begin
          rem     <= rem_next;
          off_q   <= off_q << 1;
          bit_cnt <= bit_cnt - BIT_CNT_W'(1);
          if (bit_cnt == '0) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          // The read address is on the store; data arrives next cycle.
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          if (req_q.cmd == CMD_READ) begin
            rdata_q <= ram_rdata;
          end else if (byte_changed && in_battery) begin
            change_gen <= change_gen + GEN_W'(1);
          end
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          result.read_data          <= rdata_q;
          result.passed_on          <= passed_q;
          result.dirty              <= (battery_bytes != '0) && (change_gen != persisted_gen);
          result.current_generation <= change_gen;
          state                     <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The generation moves only in the write back step.
  `CWRST_ASSERT_NEXT(a_gen_hold, clk, rst, state != ST_CHECK, $stable(change_gen), "gen moved")
  // The reduced offset must lie inside the active size.
  `CWRST_ASSERT_IMPLIES(a_rem_in_size, clk, rst, state == ST_CHECK, rem < size_q, "bad index")
  // The store is written only by the reset sweep or a write back.
  `CWRST_ASSERT_IMPLIES(a_we_src, clk, rst, ram_we, state == ST_CLEAR || state == ST_CHECK, "stray we")
  // Every transaction yields one strobe, never two in a row.
  `CWRST_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done, "result strobe too long")

endmodule
